### hw/rtl/omni_wheel_heading_to_pwm_unit_defines.svh
// assertion macros shared by the omni wheel pwm block
`ifndef OMNI_WHEEL_HEADING_TO_PWM_UNIT_DEFINES_SVH
`define OMNI_WHEEL_HEADING_TO_PWM_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define OMW_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("omw assertion failed");

// next-cycle implication, disabled during reset
`define OMW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("omw assertion failed");

`endif

### hw/rtl/omw_pkg.sv
// types, constants and sine table for the omni wheel pwm block
package omw_pkg;

	localparam int HEAD_W  = 9;
	localparam int DUTY_W  = 7;
	localparam int TBL_W   = 17;
	localparam int TBL_FRAC = 16;
	localparam int IDX_W   = 7;

	localparam logic [HEAD_W:0] FULL_TURN = 10'd360;
	localparam logic [HEAD_W:0] OFS_ONE   = 10'd420;
	localparam logic [HEAD_W:0] OFS_TWO   = 10'd660;
	localparam logic [HEAD_W-1:0] QTR_ONE = 9'd90;
	localparam logic [HEAD_W-1:0] QTR_TWO = 9'd180;
	localparam logic [HEAD_W-1:0] QTR_THREE = 9'd270;
	localparam logic [7:0] DUTY_SCALE = 8'd100;

	typedef struct packed {
		logic [HEAD_W-1:0] one;
		logic [HEAD_W-1:0] two;
		logic [HEAD_W-1:0] three;
	} angles_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty;
		logic              reverse;
	} wheel_res_t;

	// round(65536*sin(d)) for d = 0..90, clamped above 90
	function automatic logic [TBL_W-1:0] quarter_sine(input logic [IDX_W-1:0] d);
		logic [TBL_W-1:0] v;
		unique case (d)
			7'd0: v = 17'd0;      7'd1: v = 17'd1144;   7'd2: v = 17'd2287;
			7'd3: v = 17'd3430;   7'd4: v = 17'd4572;   7'd5: v = 17'd5712;
			7'd6: v = 17'd6850;   7'd7: v = 17'd7987;   7'd8: v = 17'd9121;
			7'd9: v = 17'd10252;  7'd10: v = 17'd11380; 7'd11: v = 17'd12505;
			7'd12: v = 17'd13626; 7'd13: v = 17'd14742; 7'd14: v = 17'd15855;
			7'd15: v = 17'd16962; 7'd16: v = 17'd18064; 7'd17: v = 17'd19161;
			7'd18: v = 17'd20252; 7'd19: v = 17'd21336; 7'd20: v = 17'd22415;
			7'd21: v = 17'd23486; 7'd22: v = 17'd24550; 7'd23: v = 17'd25607;
			7'd24: v = 17'd26656; 7'd25: v = 17'd27697; 7'd26: v = 17'd28729;
			7'd27: v = 17'd29753; 7'd28: v = 17'd30767; 7'd29: v = 17'd31772;
			7'd30: v = 17'd32768; 7'd31: v = 17'd33754; 7'd32: v = 17'd34729;
			7'd33: v = 17'd35693; 7'd34: v = 17'd36647; 7'd35: v = 17'd37590;
			7'd36: v = 17'd38521; 7'd37: v = 17'd39441; 7'd38: v = 17'd40348;
			7'd39: v = 17'd41243; 7'd40: v = 17'd42126; 7'd41: v = 17'd42995;
			7'd42: v = 17'd43852; 7'd43: v = 17'd44695; 7'd44: v = 17'd45525;
			7'd45: v = 17'd46341; 7'd46: v = 17'd47143; 7'd47: v = 17'd47930;
			7'd48: v = 17'd48703; 7'd49: v = 17'd49461; 7'd50: v = 17'd50203;
			7'd51: v = 17'd50931; 7'd52: v = 17'd51643; 7'd53: v = 17'd52339;
			7'd54: v = 17'd53020; 7'd55: v = 17'd53684; 7'd56: v = 17'd54332;
			7'd57: v = 17'd54963; 7'd58: v = 17'd55578; 7'd59: v = 17'd56175;
			7'd60: v = 17'd56756; 7'd61: v = 17'd57319; 7'd62: v = 17'd57865;
			7'd63: v = 17'd58393; 7'd64: v = 17'd58903; 7'd65: v = 17'd59396;
			7'd66: v = 17'd59870; 7'd67: v = 17'd60326; 7'd68: v = 17'd60764;
			7'd69: v = 17'd61183; 7'd70: v = 17'd61584; 7'd71: v = 17'd61966;
			7'd72: v = 17'd62328; 7'd73: v = 17'd62672; 7'd74: v = 17'd62997;
			7'd75: v = 17'd63303; 7'd76: v = 17'd63589; 7'd77: v = 17'd63856;
			7'd78: v = 17'd64104; 7'd79: v = 17'd64332; 7'd80: v = 17'd64540;
			7'd81: v = 17'd64729; 7'd82: v = 17'd64898; 7'd83: v = 17'd65048;
			7'd84: v = 17'd65177; 7'd85: v = 17'd65287; 7'd86: v = 17'd65376;
			7'd87: v = 17'd65446; 7'd88: v = 17'd65496; 7'd89: v = 17'd65526;
			default: v = 17'd65536;
		endcase
		return v;
	endfunction

endpackage

### hw/rtl/omw_angle.sv
// heading reduction and per-wheel angle offsets
module omw_angle
	import omw_pkg::*;
(
	input  logic [HEAD_W-1:0] heading,
	output angles_t           angles
);

	logic [HEAD_W:0] head_ext;
	logic [HEAD_W:0] head_red;
	logic [HEAD_W:0] ang_one;
	logic [HEAD_W:0] ang_two;

	always_comb begin
		head_ext = {1'b0, heading};
		head_red = (head_ext >= FULL_TURN) ? head_ext - FULL_TURN : head_ext;
		ang_one  = OFS_ONE - head_red;
		if (ang_one >= FULL_TURN) begin
			ang_one = ang_one - FULL_TURN;
		end
		ang_two  = OFS_TWO - head_red;
		if (ang_two >= FULL_TURN) begin
			ang_two = ang_two - FULL_TURN;
		end
		angles.one   = ang_one[HEAD_W-1:0];
		angles.two   = ang_two[HEAD_W-1:0];
		angles.three = head_red[HEAD_W-1:0];
	end

endmodule

### hw/rtl/omw_wheel.sv
// sine lookup and duty / direction for one wheel
module omw_wheel
	import omw_pkg::*;
#(
	parameter int FRAC_BITS = 12
) (
	input  logic [HEAD_W-1:0] angle,
	output wheel_res_t        res
);

	localparam int SH = TBL_FRAC - FRAC_BITS;
	localparam int MAG_W = FRAC_BITS + 1;
	localparam int PROD_W = FRAC_BITS + 8;
	localparam logic [MAG_W-1:0] ONE = MAG_W'(1) << FRAC_BITS;

	logic [HEAD_W-1:0] fold;
	logic              neg;
	logic [TBL_W-1:0]  tbl;
	logic [TBL_W:0]    rnd;
	logic [MAG_W-1:0]  mag;
	logic [MAG_W-1:0]  val;
	logic              rev;
	logic [PROD_W-1:0] prod;

	always_comb begin
		priority if (angle <= QTR_ONE) begin
			fold = angle;
			neg  = 1'b0;
		end else if (angle <= QTR_TWO) begin
			fold = QTR_TWO - angle;
			neg  = 1'b0;
		end else if (angle < QTR_THREE) begin
			fold = angle - QTR_TWO;
			neg  = 1'b1;
		end else begin
			fold = FULL_TURN[HEAD_W-1:0] - angle;
			neg  = 1'b1;
		end
		tbl  = quarter_sine(fold[IDX_W-1:0]);
		rnd  = ({tbl, 1'b0} >> SH) + (TBL_W+1)'(1);
		mag  = rnd[MAG_W:1];
		rev  = neg && (mag != '0);
		val  = rev ? ONE - mag : mag;
		prod = PROD_W'(val) * PROD_W'(DUTY_SCALE);
		res.duty    = prod[FRAC_BITS+DUTY_W-1:FRAC_BITS];
		res.reverse = rev;
	end

endmodule

### hw/rtl/omni_wheel_heading_to_pwm_unit.sv
// a request passes through the input register, then the result register, to result valid on the master side
// throughput: one request per cycle while the master side is ready, set by the input and result registers
// back-pressure on the master side stalls the result register, then the input register
// reset clears the stage valid flags only; data registers are not reset
`include "omni_wheel_heading_to_pwm_unit_defines.svh"
module omni_wheel_heading_to_pwm_unit
	import omw_pkg::*;
#(
	parameter int FRAC_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // heading_deg[8:0], zero fill
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // duty_one, duty_two, duty_three, reverse_one,
	                                   // reverse_two, reverse_three
);

	logic [HEAD_W-1:0] heading_s1;
	logic              valid_s1;
	logic              valid_s2;
	logic [23:0]       result_s2;
	logic              free_s2;
	logic              adv_s1;
	angles_t           angles;
	wheel_res_t        res_one;
	wheel_res_t        res_two;
	wheel_res_t        res_three;

	assign free_s2       = !valid_s2 || m_axis_tready;
	assign adv_s1        = valid_s1 && free_s2;
	assign s_axis_tready = !valid_s1 || free_s2;
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (free_s2) begin
				valid_s2 <= adv_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			heading_s1 <= s_axis_tdata[HEAD_W-1:0];
		end
		if (adv_s1) begin
			result_s2 <= {res_three.reverse, res_two.reverse, res_one.reverse,
				res_three.duty, res_two.duty, res_one.duty};
		end
	end

	omw_angle u_angle (
		.heading (heading_s1),
		.angles  (angles)
	);

	omw_wheel #(.FRAC_BITS(FRAC_BITS)) u_wheel_one (
		.angle (angles.one),
		.res   (res_one)
	);

	omw_wheel #(.FRAC_BITS(FRAC_BITS)) u_wheel_two (
		.angle (angles.two),
		.res   (res_two)
	);

	omw_wheel #(.FRAC_BITS(FRAC_BITS)) u_wheel_three (
		.angle (angles.three),
		.res   (res_three)
	);

	// duty never exceeds full scale
	`OMW_ASSERT_SAME(a_duty_range, clk, arst_n, m_axis_tvalid, (m_axis_tdata[6:0] <= 7'd100) && (m_axis_tdata[13:7] <= 7'd100) && (m_axis_tdata[20:14] <= 7'd100))
	// a reversed wheel three never runs at full duty
	`OMW_ASSERT_SAME(a_rev_duty, clk, arst_n, m_axis_tvalid && m_axis_tdata[23], m_axis_tdata[20:14] != 7'd100)
	// a request in the first stage moves to the result register when it is free
	`OMW_ASSERT_NEXT(a_adv, clk, arst_n, valid_s1 && free_s2, valid_s2)
	// a request accepted on the slave side lands in the first stage
	`OMW_ASSERT_NEXT(a_accept, clk, arst_n, s_axis_tvalid && s_axis_tready, valid_s1)

endmodule

### bench/tb_omni_wheel_heading_to_pwm_unit.sv
// self-checking stream testbench for the omni wheel heading to pwm unit
`timescale 1ns / 1ps
module tb_omni_wheel_heading_to_pwm_unit
	import omw_pkg::*;
();

	localparam int FRAC_BITS = 12;
	localparam int STALL_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int IDLE_PCT = 19;

	typedef struct packed {
		logic              reverse_three;
		logic              reverse_two;
		logic              reverse_one;
		logic [DUTY_W-1:0] duty_three;
		logic [DUTY_W-1:0] duty_two;
		logic [DUTY_W-1:0] duty_one;
	} wheel_cmd_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = 16'd0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;

	logic [HEAD_W-1:0] heading_queue [$];
	wheel_cmd_t        wheel_cmd_queue [$];

	int unsigned sine_q16 [0:90] = '{
		    0,  1144,  2287,  3430,  4572,  5712,  6850,  7987,  9121, 10252,
		11380, 12505, 13626, 14742, 15855, 16962, 18064, 19161, 20252, 21336,
		22415, 23486, 24550, 25607, 26656, 27697, 28729, 29753, 30767, 31772,
		32768, 33754, 34729, 35693, 36647, 37590, 38521, 39441, 40348, 41243,
		42126, 42995, 43852, 44695, 45525, 46341, 47143, 47930, 48703, 49461,
		50203, 50931, 51643, 52339, 53020, 53684, 54332, 54963, 55578, 56175,
		56756, 57319, 57865, 58393, 58903, 59396, 59870, 60326, 60764, 61183,
		61584, 61966, 62328, 62672, 62997, 63303, 63589, 63856, 64104, 64332,
		64540, 64729, 64898, 65048, 65177, 65287, 65376, 65446, 65496, 65526,
		65536
	};

	int send_idle_pct = IDLE_PCT;
	int recv_idle_pct = IDLE_PCT;
	int stalls_asked = 0;
	int stalls_granted = 0;
	int stall_left = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	omni_wheel_heading_to_pwm_unit #(
		.FRAC_BITS(FRAC_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int unsigned sine_magnitude(int unsigned deg);
		int unsigned t;
		t = sine_q16[deg];
		return (((t << 1) >> (16 - FRAC_BITS)) + 1) >> 1;
	endfunction

	// {reverse, duty} for one wheel angle in 0..359
	function automatic logic [DUTY_W:0] wheel_drive(int unsigned ang);
		int unsigned mag;
		int unsigned one;
		bit          neg;
		one = 1 << FRAC_BITS;
		if (ang <= 90) begin
			mag = sine_magnitude(ang);
			neg = 1'b0;
		end else if (ang <= 180) begin
			mag = sine_magnitude(180 - ang);
			neg = 1'b0;
		end else if (ang < 270) begin
			mag = sine_magnitude(ang - 180);
			neg = 1'b1;
		end else begin
			mag = sine_magnitude(360 - ang);
			neg = 1'b1;
		end
		if (neg && mag != 0)
			return {1'b1, DUTY_W'((100 * (one - mag)) >> FRAC_BITS)};
		return {1'b0, DUTY_W'((100 * mag) >> FRAC_BITS)};
	endfunction

	function automatic wheel_cmd_t predict_wheels(logic [HEAD_W-1:0] heading);
		int unsigned h;
		int unsigned ang_one;
		int unsigned ang_two;
		wheel_cmd_t  cmd;
		h = heading;
		if (h >= 360)
			h = h - 360;
		ang_one = 420 - h;
		if (ang_one >= 360)
			ang_one = ang_one - 360;
		ang_two = 660 - h;
		if (ang_two >= 360)
			ang_two = ang_two - 360;
		{cmd.reverse_one, cmd.duty_one} = wheel_drive(ang_one);
		{cmd.reverse_two, cmd.duty_two} = wheel_drive(ang_two);
		{cmd.reverse_three, cmd.duty_three} = wheel_drive(h);
		return cmd;
	endfunction

	function automatic logic [HEAD_W-1:0] random_heading();
		if ($urandom_range(3) == 0)
			return HEAD_W'($urandom_range(511));
		return HEAD_W'($urandom_range(359));
	endfunction

	task automatic check_field(string field, int expected, int actual);
		if (expected != actual) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %s: expected %0d, got %0d at %0t", field, expected, actual,
					$realtime);
		end
	endtask

	task automatic wait_drained();
		while (heading_queue.size() != 0 || wheel_cmd_queue.size() != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	// sender: holds a request until it is taken
	always @(posedge clk or negedge arst_n) begin
		bit taken;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 16'd0;
		end else begin
			taken = s_axis_tvalid && s_axis_tready;
			if (taken) begin
				wheel_cmd_queue.push_back(predict_wheels(s_axis_tdata[HEAD_W-1:0]));
				void'(heading_queue.pop_front());
			end
			if (s_axis_tvalid && !taken) begin
			end else if (heading_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {{(16 - HEAD_W){1'b0}}, heading_queue[0]};
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random back-pressure plus long hold-offs on demand
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (stalls_granted != stalls_asked) begin
				stalls_granted++;
				stall_left = STALL_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		wheel_cmd_t got;
		wheel_cmd_t exp;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (wheel_cmd_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h at %0t", m_axis_tdata, $realtime);
			end else begin
				exp = wheel_cmd_queue.pop_front();
				check_field("duty_one", exp.duty_one, got.duty_one);
				check_field("duty_two", exp.duty_two, got.duty_two);
				check_field("duty_three", exp.duty_three, got.duty_three);
				check_field("reverse_one", exp.reverse_one, got.reverse_one);
				check_field("reverse_two", exp.reverse_two, got.reverse_two);
				check_field("reverse_three", exp.reverse_three, got.reverse_three);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else if (arst_n)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		logic [HEAD_W-1:0] directed [$];
		directed = '{9'd0, 9'd360, 9'd90, 9'd180, 9'd270, 9'd60, 9'd300, 9'd240, 9'd120,
			9'd30, 9'd150, 9'd210, 9'd330, 9'd359, 9'd361, 9'd511, 9'd451, 9'd1, 9'd89,
			9'd91, 9'd179, 9'd181, 9'd269, 9'd271};
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i])
			heading_queue.push_back(directed[i]);
		wait_drained();

		repeat (600)
			heading_queue.push_back(random_heading());
		wait_drained();

		// full rate, no idling on either side
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (400)
			heading_queue.push_back(random_heading());
		wait_drained();

		recv_idle_pct = IDLE_PCT;
		repeat (300)
			heading_queue.push_back(random_heading());
		stalls_asked++;
		wait_drained();

		send_idle_pct = IDLE_PCT;
		repeat (450)
			heading_queue.push_back(random_heading());
		wait_drained();

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
